@@ sv/milne_predictor_corrector_step_macros.svh @@
// Assertion macros for the Milne step engine.
// Included by the modules that carry checks; expects clk and rst_n in scope.
`ifndef MILNE_PREDICTOR_CORRECTOR_STEP_MACROS_SVH
`define MILNE_PREDICTOR_CORRECTOR_STEP_MACROS_SVH
`ifndef SYNTHESIS
`define MPCS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpcs check failed");
`define MPCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mpcs check failed");
`else
`define MPCS_ASSERT_NOW(lbl, ante, cons)
`define MPCS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/mpcs_pkg.sv @@
// Shared constants, command codes and types of the Milne step engine.
// No dependencies; used by the controller, the datapath and the top level.
package mpcs_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int XW         = 32;
  localparam int SUM_W      = 36;   // slope sums stay below 2^35 in magnitude
  localparam int PROD_W     = 64;
  // h*sum < 2^66; after the scaling shift the quotient input fits in QW bits
  localparam int QW         = ((66 - (FRAC_BITS - 2) + 7) / 8) * 8;
  localparam int ACC_W      = FRAC_BITS + QW;
  localparam int SAT_W      = QW + 4;
  localparam int DIV_DIGITS = 8;
  localparam int DIV_STEPS  = QW / DIV_DIGITS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int STATUS_W   = 2;
  localparam int LIMIT_W    = 16;
  localparam int PTS_W      = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 2 * XW;
  localparam int OUT_DATA_W = 3 * XW;
  localparam int OP_W       = 4;

  localparam logic [PTS_W-1:0] PTS_FULL = PTS_W'(4);

  localparam logic signed [XW-1:0] STEP_SIZE_RST  = XW'(1) <<< FRAC_BITS;
  localparam logic [LIMIT_W-1:0]   STEP_LIMIT_RST = LIMIT_W'(16);
  localparam logic signed [XW-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [XW-1:0] Q_MIN = 32'sh8000_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_LOADED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LIMIT      = 2'd2;

  // datapath operations
  localparam logic [OP_W-1:0] OP_NONE        = 4'd0;
  localparam logic [OP_W-1:0] OP_CAPTURE     = 4'd1;
  localparam logic [OP_W-1:0] OP_SQ_LOAD     = 4'd2;
  localparam logic [OP_W-1:0] OP_LOAD_COMMIT = 4'd3;
  localparam logic [OP_W-1:0] OP_PSUM        = 4'd4;
  localparam logic [OP_W-1:0] OP_MUL_LO      = 4'd5;
  localparam logic [OP_W-1:0] OP_MUL_HI      = 4'd6;
  localparam logic [OP_W-1:0] OP_ACC         = 4'd7;
  localparam logic [OP_W-1:0] OP_DIV_STEP    = 4'd8;
  localparam logic [OP_W-1:0] OP_PRED        = 4'd9;
  localparam logic [OP_W-1:0] OP_SQ_STEP     = 4'd10;
  localparam logic [OP_W-1:0] OP_SLOPE_STEP  = 4'd11;
  localparam logic [OP_W-1:0] OP_CSUM        = 4'd12;
  localparam logic [OP_W-1:0] OP_COMMIT      = 4'd13;
  localparam logic [OP_W-1:0] OP_OUT_ERR     = 4'd14;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            corr_phase;  // 0: predictor pass, 1: corrector pass
  } mpcs_cmd_t;

endpackage

@@ sv/mpcs_datapath.sv @@
// Datapath of the Milne step engine: history, config registers, shared
// multiplier, divide-by-three unit and output register. Uses mpcs_pkg.
module mpcs_datapath
  import mpcs_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  mpcs_cmd_t                    cmd,
  input  logic signed [XW-1:0]         in_x,
  input  logic signed [XW-1:0]         in_y,
  input  logic                         cfg_wr,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  output logic [STATUS_W-1:0]          chk,
  output logic signed [XW-1:0]         out_x,
  output logic signed [XW-1:0]         out_yp,
  output logic signed [XW-1:0]         out_yc,
  output logic [STATUS_W-1:0]          out_status,
  output logic                         out_last
);

  function automatic logic signed [XW-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic [SAT_W-XW:0] hi;
    hi = v[SAT_W-1:XW-1];
    if (&hi || ~|hi) return v[XW-1:0];
    else if (v[SAT_W-1]) return Q_MIN;
    else return Q_MAX;
  endfunction

  function automatic logic [XW-1:0] abs32(input logic signed [XW-1:0] v);
    return v[XW-1] ? XW'(-v) : v;
  endfunction

  // y + 3x - floor(x*x / 2^F), sq is the unscaled square
  function automatic logic signed [XW-1:0] slope(input logic signed [XW-1:0] x,
                                                  input logic signed [XW-1:0] y,
                                                  input logic [PROD_W-1:0] sq);
    logic signed [SAT_W-1:0] xe;
    logic signed [SAT_W-1:0] sqe;
    logic signed [SAT_W-1:0] v;
    xe  = SAT_W'(x);
    sqe = SAT_W'(sq >> FRAC_BITS);
    v   = SAT_W'(y) + (xe <<< 1) + xe - sqe;
    return sat32(v);
  endfunction

  function automatic logic signed [XW-1:0] add_q(input logic signed [XW-1:0] y,
                                                  input logic [QW-1:0] m,
                                                  input logic neg);
    logic signed [SAT_W-1:0] mv;
    mv = SAT_W'(m);
    return sat32(SAT_W'(y) + (neg ? -mv : mv));
  endfunction

  // architectural state
  logic signed [XW-1:0]   step_size_r;
  logic [LIMIT_W-1:0]     step_limit_r;
  logic signed [XW-1:0]   y_hist_r [4];
  logic signed [XW-1:0]   s_hist_r [3];
  logic signed [XW-1:0]   last_x_r;
  logic [PTS_W-1:0]       pts_r;
  logic [LIMIT_W-1:0]     steps_r;

  // working registers
  logic signed [XW-1:0]   x_in_r, y_in_r;
  logic [XW-1:0]          habs_r;
  logic [SUM_W-1:0]       babs_r;
  logic                   neg_r;
  logic [PROD_W-1:0]      mul_r, lo_r;
  logic [QW-1:0]          div_num_r;
  logic [1:0]             div_rem_r;
  logic signed [XW-1:0]   xn_r, pred_r, sn_r;
  logic signed [XW-1:0]   out_x_r, out_yp_r, out_yc_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic                   out_last_r;

  logic [XW-1:0]          mul_a, mul_b;
  logic [PROD_W-1:0]      prod;
  logic signed [SUM_W-1:0] s0e, s1e, s2e, sne, psum, csum, sum_sel;
  logic [SUM_W-1:0]       sum_abs;
  logic signed [XW:0]     xsum;
  logic signed [XW-1:0]   xn_sat;
  logic [ACC_W-1:0]       full;
  logic [QW-1:0]          dn;
  logic [2:0]             dr;
  logic [LIMIT_W-1:0]     steps_inc;
  logic signed [XW-1:0]   slope_ld, slope_st, pred_v, corr_v;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SQ_LOAD: begin
        mul_a = abs32(x_in_r);
        mul_b = abs32(x_in_r);
      end
      OP_SQ_STEP: begin
        mul_a = abs32(xn_r);
        mul_b = abs32(xn_r);
      end
      OP_MUL_LO: begin
        mul_a = habs_r;
        mul_b = babs_r[XW-1:0];
      end
      OP_MUL_HI: begin
        mul_a = habs_r;
        mul_b = XW'(babs_r[SUM_W-1:XW]);
      end
      default: ;
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign s0e     = SUM_W'(s_hist_r[0]);
  assign s1e     = SUM_W'(s_hist_r[1]);
  assign s2e     = SUM_W'(s_hist_r[2]);
  assign sne     = SUM_W'(sn_r);
  assign psum    = (s0e <<< 1) - s1e + (s2e <<< 1);
  assign csum    = s1e + (s2e <<< 2) + sne;
  assign sum_sel = (cmd.op == OP_CSUM) ? csum : psum;
  assign sum_abs = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : sum_sel;

  assign xsum   = (XW+1)'(last_x_r) + (XW+1)'(step_size_r);
  assign xn_sat = sat32(SAT_W'(xsum));

  // low partial product plus high partial product one word up
  assign full = ACC_W'(lo_r) + {mul_r[ACC_W-XW-1:0], {XW{1'b0}}};

  // eight quotient digits of the divide by three per cycle
  always_comb begin
    dn = div_num_r;
    dr = {1'b0, div_rem_r};
    for (int i = 0; i < DIV_DIGITS; i++) begin
      dr = {dr[1:0], dn[QW-1]};
      if (dr >= 3'd3) begin
        dr = dr - 3'd3;
        dn = {dn[QW-2:0], 1'b1};
      end else begin
        dn = {dn[QW-2:0], 1'b0};
      end
    end
  end

  assign steps_inc = steps_r + LIMIT_W'(1);
  assign slope_ld  = slope(x_in_r, y_in_r, mul_r);
  assign slope_st  = slope(xn_r, pred_r, mul_r);
  assign pred_v    = add_q(y_hist_r[0], div_num_r, neg_r);
  assign corr_v    = add_q(y_hist_r[2], div_num_r, neg_r);

  always_comb begin
    if (pts_r < PTS_FULL) chk = STATUS_NOT_LOADED;
    else if (steps_r >= step_limit_r) chk = STATUS_LIMIT;
    else chk = STATUS_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_size_r  <= STEP_SIZE_RST;
      step_limit_r <= STEP_LIMIT_RST;
      for (int i = 0; i < 4; i++) y_hist_r[i] <= '0;
      for (int i = 0; i < 3; i++) s_hist_r[i] <= '0;
      last_x_r     <= '0;
      pts_r        <= '0;
      steps_r      <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          CFG_STEP_SIZE:  step_size_r  <= signed'(cfg_data);
          CFG_STEP_LIMIT: step_limit_r <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      case (cmd.op)
        OP_LOAD_COMMIT: begin
          y_hist_r[0] <= y_hist_r[1];
          y_hist_r[1] <= y_hist_r[2];
          y_hist_r[2] <= y_hist_r[3];
          y_hist_r[3] <= y_in_r;
          s_hist_r[0] <= s_hist_r[1];
          s_hist_r[1] <= s_hist_r[2];
          s_hist_r[2] <= slope_ld;
          last_x_r    <= x_in_r;
          if (pts_r < PTS_FULL) pts_r <= pts_r + PTS_W'(1);
          steps_r     <= '0;
        end
        OP_COMMIT: begin
          y_hist_r[0] <= y_hist_r[1];
          y_hist_r[1] <= y_hist_r[2];
          y_hist_r[2] <= y_hist_r[3];
          y_hist_r[3] <= pred_r;
          s_hist_r[0] <= s_hist_r[1];
          s_hist_r[1] <= s_hist_r[2];
          s_hist_r[2] <= sn_r;
          last_x_r    <= xn_r;
          steps_r     <= steps_inc;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        x_in_r <= in_x;
        y_in_r <= in_y;
      end
      OP_PSUM, OP_CSUM: begin
        habs_r <= abs32(step_size_r);
        babs_r <= sum_abs;
        neg_r  <= step_size_r[XW-1] ^ sum_sel[SUM_W-1];
        if (cmd.op == OP_PSUM) xn_r <= xn_sat;
      end
      OP_SQ_LOAD, OP_SQ_STEP, OP_MUL_LO: mul_r <= prod;
      OP_MUL_HI: begin
        mul_r <= prod;
        lo_r  <= mul_r;
      end
      OP_ACC: begin
        div_num_r <= cmd.corr_phase ? full[FRAC_BITS +: QW] : full[FRAC_BITS-2 +: QW];
        div_rem_r <= '0;
      end
      OP_DIV_STEP: begin
        div_num_r <= dn;
        div_rem_r <= dr[1:0];
      end
      OP_PRED:       pred_r <= pred_v;
      OP_SLOPE_STEP: sn_r   <= slope_st;
      OP_COMMIT: begin
        out_x_r      <= xn_r;
        out_yp_r     <= pred_r;
        out_yc_r     <= corr_v;
        out_status_r <= STATUS_OK;
        out_last_r   <= (steps_inc == step_limit_r);
      end
      OP_OUT_ERR: begin
        out_x_r      <= '0;
        out_yp_r     <= '0;
        out_yc_r     <= '0;
        out_status_r <= chk;
        out_last_r   <= 1'b0;
      end
      default: ;
    endcase
  end

  assign out_x      = out_x_r;
  assign out_yp     = out_yp_r;
  assign out_yc     = out_yc_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

@@ sv/mpcs_ctrl.sv @@
// Sequencer of the Milne step engine: walks the datapath through load and
// step operations and owns the result valid flag. Uses mpcs_pkg and the macros.
`include "milne_predictor_corrector_step_macros.svh"
module mpcs_ctrl
  import mpcs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_req,
  input  logic                out_tready,
  output logic                out_tvalid,
  input  logic [STATUS_W-1:0] chk,
  output mpcs_cmd_t           cmd
);

  localparam int SW = 4;
  localparam logic [SW-1:0] S_IDLE     = 4'd0;
  localparam logic [SW-1:0] S_LD_SQ    = 4'd1;
  localparam logic [SW-1:0] S_LD_SLOPE = 4'd2;
  localparam logic [SW-1:0] S_PSUM     = 4'd3;
  localparam logic [SW-1:0] S_MUL_LO   = 4'd4;
  localparam logic [SW-1:0] S_MUL_HI   = 4'd5;
  localparam logic [SW-1:0] S_ACC      = 4'd6;
  localparam logic [SW-1:0] S_DIV      = 4'd7;
  localparam logic [SW-1:0] S_PRED     = 4'd8;
  localparam logic [SW-1:0] S_SQ       = 4'd9;
  localparam logic [SW-1:0] S_SLOPE    = 4'd10;
  localparam logic [SW-1:0] S_CSUM     = 4'd11;
  localparam logic [SW-1:0] S_CORR     = 4'd12;
  localparam logic [SW-1:0] S_ERR      = 4'd13;

  logic [SW-1:0]        state_r, state_nxt;
  logic                 phase_r, phase_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_free;
  logic [OP_W-1:0]      op;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    op            = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op = OP_CAPTURE;
          if (!in_req) state_nxt = S_LD_SQ;
          else if (chk != STATUS_OK) state_nxt = S_ERR;
          else state_nxt = S_PSUM;
        end
      end
      S_LD_SQ: begin
        op        = OP_SQ_LOAD;
        state_nxt = S_LD_SLOPE;
      end
      S_LD_SLOPE: begin
        op        = OP_LOAD_COMMIT;
        state_nxt = S_IDLE;
      end
      S_PSUM: begin
        op        = OP_PSUM;
        phase_nxt = 1'b0;
        state_nxt = S_MUL_LO;
      end
      S_MUL_LO: begin
        op        = OP_MUL_LO;
        state_nxt = S_MUL_HI;
      end
      S_MUL_HI: begin
        op        = OP_MUL_HI;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        op        = OP_ACC;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        op      = OP_DIV_STEP;
        cnt_nxt = cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = phase_r ? S_CORR : S_PRED;
      end
      S_PRED: begin
        op        = OP_PRED;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        op        = OP_SQ_STEP;
        state_nxt = S_SLOPE;
      end
      S_SLOPE: begin
        op        = OP_SLOPE_STEP;
        state_nxt = S_CSUM;
      end
      S_CSUM: begin
        op        = OP_CSUM;
        phase_nxt = 1'b1;
        state_nxt = S_MUL_LO;
      end
      S_CORR: begin
        if (out_free) begin
          op            = OP_COMMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_ERR: begin
        if (out_free) begin
          op            = OP_OUT_ERR;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready      = (state_r == S_IDLE);
  assign out_tvalid     = out_valid_r;
  assign cmd.op         = op;
  assign cmd.corr_phase = phase_r;

  `MPCS_ASSERT_NOW(a_no_overwrite, (op == OP_COMMIT) || (op == OP_OUT_ERR), !out_valid_r || out_tready)
  `MPCS_ASSERT_NEXT(a_step_busy, in_tvalid && in_tready && in_req, state_r != S_IDLE)
  `MPCS_ASSERT_NOW(a_div_count, state_r == S_DIV, cnt_r < DIV_CNT_W'(DIV_STEPS))
  `MPCS_ASSERT_NOW(a_pred_phase, (state_r == S_PRED) || (state_r == S_SQ), !phase_r)
  `MPCS_ASSERT_NEXT(a_result_set, (state_r == S_CORR) && out_free, out_valid_r)

endmodule

@@ sv/milne_predictor_corrector_step.sv @@
// Top level of the Milne predictor-corrector step engine.
// Joins mpcs_ctrl and mpcs_datapath; uses mpcs_pkg.
//
//  channel  dir  beat fields (low bit first)
//  in_      in   tdata: x_in[31:0], y_in[63:32]; tuser: req_type
//  out_     out  tdata: x_out, y_predicted, y_corrected; tuser: status; tlast: last_step
//  cfg_     in   cfg_index 0 step_size, 1 step_limit; cfg_data value
//
// A load beat squares x and commits; a step multiplies and divides for the predictor,
// takes the new slope, multiplies and divides for the corrector and commits; a rejected
// step writes an error. The one 32x32 multiplier, taken twice per product, and the
// divide by three at eight bits a cycle set a step's length. Reset (rst_n low,
// synchronous) restores the registers to their defaults and empties the history; there
// is no clearing pass. A result waits in the output register while loads go on; a step
// then holds in its last cycle until that register is free. cfg_ready is always high.
module milne_predictor_corrector_step
  import mpcs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // x_in, y_in
  input  logic [0:0]            in_tuser,   // req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // x_out, y_predicted, y_corrected
  output logic [STATUS_W-1:0]   out_tuser,  // status
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  mpcs_cmd_t            cmd;
  logic [STATUS_W-1:0]  chk;
  logic signed [XW-1:0] out_x, out_yp, out_yc;

  assign cfg_ready = 1'b1;

  mpcs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_req     (in_tuser[0]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .chk        (chk),
    .cmd        (cmd)
  );

  mpcs_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_x       (signed'(in_tdata[XW-1:0])),
    .in_y       (signed'(in_tdata[2*XW-1:XW])),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .chk        (chk),
    .out_x      (out_x),
    .out_yp     (out_yp),
    .out_yc     (out_yc),
    .out_status (out_tuser),
    .out_last   (out_tlast)
  );

  assign out_tdata = {out_yc, out_yp, out_x};

endmodule
